// ===== src/rirc_pkg.sv =====
// ----------------------------------------------------------------------------
// rirc_pkg: row index run coalescer package
// Shared widths, register indexes, status codes and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package rirc_pkg;

  localparam int unsigned MAX_LIST  = 4096;
  localparam int unsigned POS_W     = $clog2(MAX_LIST + 1);

  localparam int unsigned ROW_W     = 32;
  localparam int unsigned DST_W     = 12;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned TOT_W     = 13;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CAP_W     = 13;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_CAPACITY = 1'd1;

  localparam logic             MODE_COPY      = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd4096;
  localparam logic [ROW_W-1:0] PAD_SOURCE     = '1;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_CAPACITY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_TOO_LONG = 2'd2;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [ROW_W-1:0] run_source;
    logic [DST_W-1:0]        run_destination;
    logic [LEN_W-1:0]        run_length;
    logic                    run_valid;
    logic [TOT_W-1:0]        run_total;
    logic [STAT_W-1:0]       list_status;
    logic                    result_last;
  } result_t;

  // up to two results written per accepted item
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

// ===== src/rirc_if.sv =====
// ----------------------------------------------------------------------------
// rirc_if: row index run coalescer channels
// Valid/ready channels for row list items and run result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rirc_in_if;
  import rirc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ROW_W-1:0] row_index;
  logic                    list_last;

  modport source (output valid, output row_index, output list_last, input ready);
  modport sink   (input valid, input row_index, input list_last, output ready);
endinterface

interface rirc_out_if;
  import rirc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ROW_W-1:0] run_source;
  logic [DST_W-1:0]        run_destination;
  logic [LEN_W-1:0]        run_length;
  logic                    run_valid;
  logic [TOT_W-1:0]        run_total;
  logic [STAT_W-1:0]       list_status;
  logic                    result_last;

  modport source (output valid, output run_source, output run_destination,
                  output run_length, output run_valid, output run_total,
                  output list_status, output result_last, input ready);
  modport sink   (input valid, input run_source, input run_destination,
                  input run_length, input run_valid, input run_total,
                  input list_status, input result_last, output ready);
endinterface

`default_nettype wire

// ===== src/rirc_core.sv =====
// ----------------------------------------------------------------------------
// rirc_core: run tracking datapath
// Holds the open run and list state, config registers, and builds the
// results caused by one item combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module rirc_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic signed [rirc_pkg::ROW_W-1:0] row_index_i,
  input  wire logic                             list_last_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [rirc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [rirc_pkg::CFG_W-1:0]       cfg_data_i,
  output rirc_pkg::push_t                       push_o
);
  import rirc_pkg::*;

  logic                 mode_q;
  logic [CAP_W-1:0]     cap_q;

  logic [ROW_W-1:0]     src_q, src_d;
  logic [POS_W-1:0]     dst_q, dst_d;
  logic [POS_W-1:0]     len_q, len_d;
  logic                 open_q, open_d;
  logic [POS_W-1:0]     runs_q, runs_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [STAT_W-1:0]    err_q, err_d;

  logic                 pad;
  logic                 adjacent;
  logic                 src_adj;
  logic                 cap_ok;
  logic [POS_W:0]       dst_end;
  logic [ROW_W:0]       src_end;
  logic                 close_run;
  logic                 start_run;
  logic [ROW_W-1:0]     start_src;
  logic                 a_valid;
  logic                 b_valid;
  result_t              res_a;
  result_t              res_b;
  result_t              res_tail;
  logic [31:0]          dst_wide_a, len_wide_a, dst_wide_b, len_wide_b, runs_wide;

  assign pad      = row_index_i[ROW_W-1];
  assign dst_end  = {1'b0, dst_q} + {1'b0, len_q};
  assign adjacent = open_q && ({1'b0, pos_q} == dst_end);
  assign src_end  = {1'b0, src_q} + (ROW_W+1)'(len_q);
  assign src_adj  = (src_end == {1'b0, row_index_i});
  assign cap_ok   = 32'(runs_q) < 32'(cap_q);

  always_comb begin
    src_d     = src_q;
    dst_d     = dst_q;
    len_d     = len_q;
    open_d    = open_q;
    runs_d    = runs_q;
    err_d     = err_q;
    close_run = 1'b0;
    start_run = 1'b0;
    start_src = row_index_i;

    if (err_q == STATUS_OK) begin
      if (pos_q == POS_W'(MAX_LIST)) begin
        // held run is dropped, not emitted
        err_d  = STATUS_TOO_LONG;
        open_d = 1'b0;
      end else if (mode_q == MODE_COPY) begin
        if (pad) begin
          close_run = 1'b1;
        end else if (adjacent && (src_q != PAD_SOURCE) && src_adj) begin
          len_d = len_q + 1'b1;
        end else begin
          close_run = 1'b1;
          start_run = 1'b1;
        end
      end else begin
        if (!pad) begin
          close_run = 1'b1;
        end else if (adjacent && (src_q == PAD_SOURCE)) begin
          len_d = len_q + 1'b1;
        end else begin
          close_run = 1'b1;
          start_run = 1'b1;
          start_src = PAD_SOURCE;
        end
      end
    end

    if (close_run) begin
      open_d = 1'b0;
    end
    if (start_run) begin
      if (cap_ok) begin
        src_d  = start_src;
        dst_d  = pos_q;
        len_d  = POS_W'(1);
        open_d = 1'b1;
        runs_d = runs_q + 1'b1;
      end else begin
        err_d  = STATUS_CAPACITY;
        open_d = 1'b0;
      end
    end

    pos_d = (pos_q == POS_W'(MAX_LIST)) ? pos_q : pos_q + 1'b1;
  end

  assign a_valid = close_run && open_q;
  assign b_valid = list_last_i && (err_d == STATUS_OK) && open_d;

  assign dst_wide_a = 32'(dst_q);
  assign len_wide_a = 32'(len_q);
  assign dst_wide_b = 32'(dst_d);
  assign len_wide_b = 32'(len_d);
  assign runs_wide  = 32'(runs_d);

  always_comb begin
    res_a                 = '0;
    res_a.run_source      = src_q;
    res_a.run_destination = dst_wide_a[DST_W-1:0];
    res_a.run_length      = len_wide_a[LEN_W-1:0];
    res_a.run_valid       = 1'b1;

    res_b                 = '0;
    res_b.run_source      = src_d;
    res_b.run_destination = dst_wide_b[DST_W-1:0];
    res_b.run_length      = len_wide_b[LEN_W-1:0];
    res_b.run_valid       = 1'b1;

    push_o = '0;
    if (a_valid) begin
      push_o.first  = res_a;
      push_o.second = res_b;
      push_o.count  = b_valid ? 2'd2 : 2'd1;
    end else begin
      // when nothing closes, the last result is the open run or an empty one
      push_o.first  = b_valid ? res_b : '0;
      push_o.count  = list_last_i ? 2'd1 : 2'd0;
    end

    res_tail = (push_o.count == 2'd2) ? push_o.second : push_o.first;
    res_tail.run_total   = runs_wide[TOT_W-1:0];
    res_tail.list_status = err_d;
    res_tail.result_last = 1'b1;
    if (list_last_i) begin
      if (push_o.count == 2'd2) begin
        push_o.second = res_tail;
      end else begin
        push_o.first = res_tail;
      end
    end

    if (!accept_i) begin
      push_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_COPY;
      cap_q  <= CAPACITY_RESET;
      src_q  <= '0;
      dst_q  <= '0;
      len_q  <= '0;
      open_q <= 1'b0;
      runs_q <= '0;
      pos_q  <= '0;
      err_q  <= STATUS_OK;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_RUN_MODE:     mode_q <= cfg_data_i[0];
          REG_RUN_CAPACITY: cap_q  <= cfg_data_i[CAP_W-1:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        if (list_last_i) begin
          src_q  <= '0;
          dst_q  <= '0;
          len_q  <= '0;
          open_q <= 1'b0;
          runs_q <= '0;
          pos_q  <= '0;
          err_q  <= STATUS_OK;
        end else begin
          src_q  <= src_d;
          dst_q  <= dst_d;
          len_q  <= len_d;
          open_q <= open_d;
          runs_q <= runs_d;
          pos_q  <= pos_d;
          err_q  <= err_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rirc_queue.sv =====
// ----------------------------------------------------------------------------
// rirc_queue: result queue
// Small register queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
`default_nettype none

module rirc_queue (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  rirc_pkg::push_t                         push_i,
  input  wire logic                               pop_i,
  output rirc_pkg::result_t                       head_o,
  output logic [rirc_pkg::QUEUE_LVL_W-1:0]        level_o
);
  import rirc_pkg::*;

  result_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_q, rd_q;
  logic [QUEUE_PTR_W-1:0]  wr_next;
  logic [QUEUE_LVL_W-1:0]  level_q, level_d;
  logic                    pop;

  assign wr_next = wr_q + 1'b1;
  assign pop     = pop_i && (level_q != '0);
  assign head_o  = mem_q[rd_q];
  assign level_o = level_q;
  assign level_d = level_q + QUEUE_LVL_W'(push_i.count) - QUEUE_LVL_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_q + QUEUE_PTR_W'(push_i.count);
      rd_q    <= rd_q + QUEUE_PTR_W'(pop);
      level_q <= level_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/row_index_run_coalescer_top.sv =====
// ----------------------------------------------------------------------------
// row_index_run_coalescer_top: row list to copy/padding run descriptors
// Merges row indices (copy mode) or padding (padding mode) into runs.
// ----------------------------------------------------------------------------
// Results are registered in the result queue and offered from its head.
// Throughput: one item per cycle while the queue has room for two results;
//   the single-read result queue (depth 4) gives one result per pop.
// Reset: asynchronous, clears run state, list position, error and queue;
//   run_mode resets to copy runs, run_capacity to 4096.
`default_nettype none

module row_index_run_coalescer_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  rirc_in_if.sink                               item_in,
  rirc_out_if.source                            run_out,
  input  wire logic                             cfg_we_i,
  input  wire logic [rirc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [rirc_pkg::CFG_W-1:0]       cfg_data_i
);
  import rirc_pkg::*;

  push_t                   push;
  result_t                 head;
  logic [QUEUE_LVL_W-1:0]  level;
  logic                    accept;

  // room for two results regardless of the pop this cycle
  assign item_in.ready = (level <= QUEUE_LVL_W'(QUEUE_DEPTH - 2));
  assign accept        = item_in.valid && item_in.ready;

  rirc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .row_index_i (item_in.row_index),
    .list_last_i (item_in.list_last),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push)
  );

  rirc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (run_out.ready),
    .head_o  (head),
    .level_o (level)
  );

  assign run_out.valid           = (level != '0);
  assign run_out.run_source      = head.run_source;
  assign run_out.run_destination = head.run_destination;
  assign run_out.run_length      = head.run_length;
  assign run_out.run_valid       = head.run_valid;
  assign run_out.run_total       = head.run_total;
  assign run_out.list_status     = head.list_status;
  assign run_out.result_last     = head.result_last;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= QUEUE_LVL_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_in.list_last |=> run_out.valid)
    else $error("last item produced no result");

  a_tail_only_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_out.valid && !run_out.result_last |->
      run_out.list_status == STATUS_OK && run_out.run_total == '0)
    else $error("count or status on a non-final result");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_out.valid && !run_out.run_valid |->
      run_out.run_length == '0 && run_out.result_last)
    else $error("empty result not final or with length");

endmodule

`default_nettype wire
